### src/ncab_pkg.sv
// ---------------------------------------------------------------------------
// ncab_pkg
// types and constants shared by the nal config to annex-b converter
// ---------------------------------------------------------------------------
package ncab_pkg;

   localparam logic [4:0] AVC_HEADER_BYTES  = 5'd5;
   localparam logic [4:0] HEVC_HEADER_BYTES = 5'd22;
   localparam logic [4:0] AVC_COUNT_MASK    = 5'h1f;
   localparam logic [7:0] AVC_GROUPS        = 8'd2;
   localparam int         QUEUE_DEPTH       = 4;

   // configuration register indexes
   localparam logic CSR_HEVC_MODE   = 1'b0;
   localparam logic CSR_LENGTH_ONLY = 1'b1;

   typedef enum logic [3:0] {
      PH_HEADER,
      PH_AVC_COUNT,
      PH_HEVC_ARRAYS,
      PH_HEVC_TYPE,
      PH_COUNT_HI,
      PH_COUNT_LO,
      PH_SIZE_HI,
      PH_SIZE_LO,
      PH_PAYLOAD,
      PH_DONE
   } phase_type;

   typedef enum logic [1:0] {
      CMD_NONE,
      CMD_BYTE,
      CMD_START
   } cmd_kind_type;

   typedef struct packed {
      logic hevc_mode;
      logic length_only;
   } cfg_type;

   // one queued command: data part plus optional record summary
   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   data;
      logic         summary;
      logic         status;
      logic [2:0]   prefix;
      logic [31:0]  total;
   } queue_entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

### src/nal_config_to_annexb_unit.sv
// ---------------------------------------------------------------------------
// nal_config_to_annexb_unit
// rewrites avcC / hvcC parameter-set units as an annex-b byte stream
// ---------------------------------------------------------------------------
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  in_byte, in_last
//   rsp      out        rsp_valid/rsp_stall  out_byte .. run_end
//   csr      in         csr_write_enable     csr_index, csr_write_data
//
// one request byte is accepted per cycle while the command queue has room
// in byte mode a unit size low byte yields four start codes, a payload byte
// one, a record summary one more; header, count, type and size high bytes
// none; the unstalled back end sends one response per cycle, so start codes
// fill the four-entry queue; req_stall is high only while that queue is full
// reset (synchronous) clears the walk, the queue and the output register
module nal_config_to_annexb_unit #(
   parameter int TOTAL_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_byte,
   input  logic        req_in_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_byte_valid,
   output logic        rsp_record_done,
   output logic        rsp_status,
   output logic [2:0]  rsp_length_field_bytes,
   output logic [31:0] rsp_total_length,
   output logic        rsp_run_end,
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic        csr_write_data
);

   ncab_pkg::cfg_type          cfg_ff;
   ncab_pkg::queue_entry_type  push_entry;
   ncab_pkg::queue_entry_type  head;
   ncab_pkg::queue_status_type qstatus;
   logic                       accept;
   logic                       push;
   logic                       pop;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            ncab_pkg::CSR_HEVC_MODE:   cfg_ff.hevc_mode   <= csr_write_data;
            ncab_pkg::CSR_LENGTH_ONLY: cfg_ff.length_only <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   // stall while the queue is full so every accepted request has a slot
   assign req_stall = qstatus.full;
   assign accept    = req_valid && !req_stall;

   ncab_front #(
      .TOTAL_WIDTH (TOTAL_WIDTH)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .accept  (accept),
      .in_byte (req_in_byte),
      .in_last (req_in_last),
      .push    (push),
      .entry   (push_entry)
   );

   ncab_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .status     (qstatus)
   );

   ncab_back u_back (
      .clock                  (clock),
      .reset                  (reset),
      .head                   (head),
      .qstatus                (qstatus),
      .pop                    (pop),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_out_byte           (rsp_out_byte),
      .rsp_byte_valid         (rsp_byte_valid),
      .rsp_record_done        (rsp_record_done),
      .rsp_status             (rsp_status),
      .rsp_length_field_bytes (rsp_length_field_bytes),
      .rsp_total_length       (rsp_total_length),
      .rsp_run_end            (rsp_run_end)
   );

endmodule

### src/ncab_front.sv
// ---------------------------------------------------------------------------
// ncab_front
// walks the record one accepted byte a cycle and queues output commands
// ---------------------------------------------------------------------------
module ncab_front #(
   parameter int TOTAL_WIDTH = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  ncab_pkg::cfg_type         cfg,
   input  logic                      accept,
   input  logic [7:0]                in_byte,
   input  logic                      in_last,
   output logic                      push,
   output ncab_pkg::queue_entry_type entry
);

   localparam int SUM_W = ((TOTAL_WIDTH > 17) ? TOTAL_WIDTH : 17) + 1;
   localparam logic [SUM_W-1:0] LIMIT = SUM_W'({TOTAL_WIDTH{1'b1}});

   ncab_pkg::phase_type    phase_ff, phase_in;
   logic [4:0]             hpos_ff, hpos_in;
   logic [7:0]             groups_ff, groups_in;
   logic [15:0]            units_ff, units_in;
   logic [15:0]            payload_ff, payload_in;
   logic [7:0]             hold_ff, hold_in;
   logic [2:0]             prefix_ff, prefix_in;
   logic [TOTAL_WIDTH-1:0] total_ff, total_in;
   logic                   finished_ff, finished_in;

   logic [4:0]             hlen;
   logic                   do_decide;
   logic [SUM_W-1:0]       sum;
   ncab_pkg::cmd_kind_type emit;

   assign hlen = cfg.hevc_mode ? ncab_pkg::HEVC_HEADER_BYTES : ncab_pkg::AVC_HEADER_BYTES;

   // next state of the walk
   always_comb begin
      phase_in    = phase_ff;
      hpos_in     = hpos_ff;
      groups_in   = groups_ff;
      units_in    = units_ff;
      payload_in  = payload_ff;
      hold_in     = hold_ff;
      prefix_in   = prefix_ff;
      total_in    = total_ff;
      finished_in = finished_ff;
      do_decide   = 1'b0;
      sum         = SUM_W'(total_ff) + SUM_W'({1'b0, hold_ff, in_byte} + 17'd4);
      unique case (phase_ff)
         ncab_pkg::PH_HEADER: begin
            hpos_in = hpos_ff + 5'd1;
            if (hpos_in >= hlen) begin
               prefix_in = {1'b0, in_byte[1:0]} + 3'd1;
               if (cfg.hevc_mode) begin
                  phase_in = ncab_pkg::PH_HEVC_ARRAYS;
               end else begin
                  groups_in = ncab_pkg::AVC_GROUPS;
                  phase_in  = ncab_pkg::PH_AVC_COUNT;
               end
            end
         end
         ncab_pkg::PH_AVC_COUNT: begin
            groups_in = groups_ff - 8'd1;
            units_in  = {11'd0, in_byte[4:0] & ncab_pkg::AVC_COUNT_MASK};
            do_decide = 1'b1;
         end
         ncab_pkg::PH_HEVC_ARRAYS: begin
            groups_in = in_byte;
            units_in  = 16'd0;
            do_decide = 1'b1;
         end
         ncab_pkg::PH_HEVC_TYPE: begin
            groups_in = groups_ff - 8'd1;
            phase_in  = ncab_pkg::PH_COUNT_HI;
         end
         ncab_pkg::PH_COUNT_HI: begin
            hold_in  = in_byte;
            phase_in = ncab_pkg::PH_COUNT_LO;
         end
         ncab_pkg::PH_COUNT_LO: begin
            units_in  = {hold_ff, in_byte};
            do_decide = 1'b1;
         end
         ncab_pkg::PH_SIZE_HI: begin
            hold_in  = in_byte;
            phase_in = ncab_pkg::PH_SIZE_LO;
         end
         ncab_pkg::PH_SIZE_LO: begin
            payload_in = {hold_ff, in_byte};
            units_in   = units_ff - 16'd1;
            total_in   = (sum > LIMIT) ? {TOTAL_WIDTH{1'b1}} : TOTAL_WIDTH'(sum);
            if (payload_in != 16'd0) begin
               phase_in = ncab_pkg::PH_PAYLOAD;
            end else begin
               do_decide = 1'b1;
            end
         end
         ncab_pkg::PH_PAYLOAD: begin
            payload_in = payload_ff - 16'd1;
            do_decide  = (payload_in == 16'd0);
         end
         ncab_pkg::PH_DONE: begin
         end
         default: begin
         end
      endcase
      if (do_decide) begin
         if (units_in != 16'd0) begin
            phase_in = ncab_pkg::PH_SIZE_HI;
         end else if (groups_in != 8'd0) begin
            phase_in = cfg.hevc_mode ? ncab_pkg::PH_HEVC_TYPE : ncab_pkg::PH_AVC_COUNT;
         end else begin
            phase_in    = ncab_pkg::PH_DONE;
            finished_in = 1'b1;
         end
      end
   end

   // command for the back end
   always_comb begin
      emit = ncab_pkg::CMD_NONE;
      unique case (phase_ff)
         ncab_pkg::PH_SIZE_LO: emit = cfg.length_only ? ncab_pkg::CMD_NONE : ncab_pkg::CMD_START;
         ncab_pkg::PH_PAYLOAD: emit = cfg.length_only ? ncab_pkg::CMD_NONE : ncab_pkg::CMD_BYTE;
         default:              emit = ncab_pkg::CMD_NONE;
      endcase
      push          = accept && ((emit != ncab_pkg::CMD_NONE) || in_last);
      entry.kind    = emit;
      entry.data    = in_byte;
      entry.summary = in_last;
      entry.status  = !finished_in;
      entry.prefix  = prefix_in;
      entry.total   = 32'(total_in);
   end

   always_ff @(posedge clock) begin
      if (reset || (accept && in_last)) begin
         phase_ff    <= ncab_pkg::PH_HEADER;
         hpos_ff     <= 5'd0;
         groups_ff   <= 8'd0;
         units_ff    <= 16'd0;
         payload_ff  <= 16'd0;
         hold_ff     <= 8'd0;
         prefix_ff   <= 3'd1;
         total_ff    <= '0;
         finished_ff <= 1'b0;
      end else if (accept) begin
         phase_ff    <= phase_in;
         hpos_ff     <= hpos_in;
         groups_ff   <= groups_in;
         units_ff    <= units_in;
         payload_ff  <= payload_in;
         hold_ff     <= hold_in;
         prefix_ff   <= prefix_in;
         total_ff    <= total_in;
         finished_ff <= finished_in;
      end
   end

endmodule

### src/ncab_queue.sv
// ---------------------------------------------------------------------------
// ncab_queue
// small command queue between the parser and the output sequencer
// ---------------------------------------------------------------------------
module ncab_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  ncab_pkg::queue_entry_type push_entry,
   input  logic                      pop,
   output ncab_pkg::queue_entry_type head,
   output ncab_pkg::queue_status_type status
);

   localparam int PW = $clog2(ncab_pkg::QUEUE_DEPTH);

   ncab_pkg::queue_entry_type slot_ff [ncab_pkg::QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [PW:0]   count_ff;

   assign head         = slot_ff[rd_ptr_ff];
   assign status.full  = (count_ff == (PW+1)'(ncab_pkg::QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + PW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + PW'(1);
         end
         count_ff <= count_ff + (PW+1)'(push) - (PW+1)'(pop);
      end
   end

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      !(push && status.full && !pop)) else $error("queue overrun");
   a_no_underrun: assert property (@(posedge clock) disable iff (reset)
      !(pop && status.empty)) else $error("queue underrun");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (PW+1)'(ncab_pkg::QUEUE_DEPTH)) else $error("queue count out of range");

endmodule

### src/ncab_back.sv
// ---------------------------------------------------------------------------
// ncab_back
// expands queued commands into response items through an output register
// ---------------------------------------------------------------------------
module ncab_back (
   input  logic                       clock,
   input  logic                       reset,
   input  ncab_pkg::queue_entry_type  head,
   input  ncab_pkg::queue_status_type qstatus,
   output logic                       pop,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [7:0]                 rsp_out_byte,
   output logic                       rsp_byte_valid,
   output logic                       rsp_record_done,
   output logic                       rsp_status,
   output logic [2:0]                 rsp_length_field_bytes,
   output logic [31:0]                rsp_total_length,
   output logic                       rsp_run_end
);

   logic [2:0]  step_ff, step_in;
   logic        valid_ff, valid_in;
   logic [7:0]  byte_ff, byte_in;
   logic        bv_ff, bv_in;
   logic        done_ff, done_in;
   logic        status_ff, status_in;
   logic [2:0]  prefix_ff, prefix_in;
   logic [31:0] total_ff, total_in;
   logic        end_ff, end_in;

   logic        load;
   logic [2:0]  n_data;
   logic [2:0]  n_items;
   logic        is_data;
   logic        last_item;

   always_comb begin
      case (head.kind)
         ncab_pkg::CMD_START: n_data = 3'd4;
         ncab_pkg::CMD_BYTE:  n_data = 3'd1;
         default:             n_data = 3'd0;
      endcase
      n_items   = n_data + {2'd0, head.summary};
      is_data   = (step_ff < n_data);
      last_item = (step_ff == n_items - 3'd1);
      load      = !valid_ff || !rsp_stall;
      pop       = load && !qstatus.empty && last_item;

      step_in   = step_ff;
      valid_in  = valid_ff;
      byte_in   = byte_ff;
      bv_in     = bv_ff;
      done_in   = done_ff;
      status_in = status_ff;
      prefix_in = prefix_ff;
      total_in  = total_ff;
      end_in    = end_ff;
      if (load) begin
         valid_in = !qstatus.empty;
         if (!qstatus.empty) begin
            step_in   = last_item ? 3'd0 : step_ff + 3'd1;
            // start code is 00 00 00 01
            if (head.kind == ncab_pkg::CMD_START) begin
               byte_in = (step_ff == 3'd3) ? 8'h01 : 8'h00;
            end else begin
               byte_in = head.data;
            end
            if (!is_data) begin
               byte_in = 8'h00;
            end
            bv_in     = is_data;
            done_in   = !is_data;
            status_in = !is_data && head.status;
            prefix_in = head.prefix;
            total_in  = head.total;
            end_in    = last_item;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= 3'd0;
         valid_ff <= 1'b0;
      end else begin
         step_ff  <= step_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff   <= byte_in;
      bv_ff     <= bv_in;
      done_ff   <= done_in;
      status_ff <= status_in;
      prefix_ff <= prefix_in;
      total_ff  <= total_in;
      end_ff    <= end_in;
   end

   assign rsp_valid              = valid_ff;
   assign rsp_out_byte           = byte_ff;
   assign rsp_byte_valid         = bv_ff;
   assign rsp_record_done        = done_ff;
   assign rsp_status             = status_ff;
   assign rsp_length_field_bytes = prefix_ff;
   assign rsp_total_length       = total_ff;
   assign rsp_run_end            = end_ff;

   a_done_ends_run: assert property (@(posedge clock) disable iff (reset)
      valid_ff && done_ff |-> end_ff) else $error("summary not last of its run");
   a_kind_exclusive: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (bv_ff != done_ff)) else $error("response is neither data nor summary");

endmodule

### tb/sv/nal_config_to_annexb_unit_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// nal_config_to_annexb_unit_tb
// self-checking bench for the avcC / hvcC to annex-b converter: a directed
// table, then random records in both layouts and both output modes, every
// response checked in order against a bit-accurate predictor of the walk
// ---------------------------------------------------------------------------
module nal_config_to_annexb_unit_tb;

   localparam int PHASE_REQUESTS = 8;   // at least this many random requests per settings phase
   localparam int DRAIN_CYCLES   = 20;  // queue depth plus pipeline, with margin
   localparam int START_CODE_LEN = 4;

   // one response as seen on the rsp channel
   typedef struct packed {
      logic [7:0]  data;
      logic        byte_valid;
      logic        record_done;
      logic        status;
      logic [2:0]  prefix;
      logic [31:0] total;
      logic        run_end;
   } annexb_out_type;

   // one request; typed rows carry the summary that the record must end with
   typedef struct packed {
      logic [7:0]  data;
      logic        last;
      logic        typed;
      logic        status;
      logic [2:0]  prefix;
      logic [31:0] total;
   } stim_row_type;

   localparam int DIRECTED_ROWS = 24;
   localparam stim_row_type DIRECTED [DIRECTED_ROWS] = '{
      // lone byte right after reset: truncated header, reset prefix
      '{8'hff, 1'b1, 1'b1, 1'b1, 3'd1, 32'd0},
      // avcC header, last header byte 0xff gives a 4-byte prefix
      '{8'h01, 1'b0, 1'b0, 1'b0, 3'd0, 32'd0},
      '{8'h64, 1'b0, 1'b0, 1'b0, 3'd0, 32'd0},
      '{8'h00, 1'b0, 1'b0, 1'b0, 3'd0, 32'd0},
      '{8'h1f, 1'b0, 1'b0, 1'b0, 3'd0, 32'd0},
      '{8'hff, 1'b0, 1'b0, 1'b0, 3'd0, 32'd0},
      // sps count with the reserved high bits set, one unit of two bytes
      '{8'he1, 1'b0, 1'b0, 1'b0, 3'd0, 32'd0},
      '{8'h00, 1'b0, 1'b0, 1'b0, 3'd0, 32'd0},
      '{8'h02, 1'b0, 1'b0, 1'b0, 3'd0, 32'd0},
      '{8'h00, 1'b0, 1'b0, 1'b0, 3'd0, 32'd0},
      '{8'hff, 1'b0, 1'b0, 1'b0, 3'd0, 32'd0},
      // no pps, then a trailing byte that ends the record cleanly
      '{8'h00, 1'b0, 1'b0, 1'b0, 3'd0, 32'd0},
      '{8'hab, 1'b1, 1'b1, 1'b0, 3'd4, 32'd6},
      // second record: 1-byte prefix and a zero-size unit
      '{8'h01, 1'b0, 1'b0, 1'b0, 3'd0, 32'd0},
      '{8'h42, 1'b0, 1'b0, 1'b0, 3'd0, 32'd0},
      '{8'hc0, 1'b0, 1'b0, 1'b0, 3'd0, 32'd0},
      '{8'h1e, 1'b0, 1'b0, 1'b0, 3'd0, 32'd0},
      '{8'hfc, 1'b0, 1'b0, 1'b0, 3'd0, 32'd0},
      '{8'h01, 1'b0, 1'b0, 1'b0, 3'd0, 32'd0},
      '{8'h00, 1'b0, 1'b0, 1'b0, 3'd0, 32'd0},
      '{8'h00, 1'b0, 1'b0, 1'b0, 3'd0, 32'd0},
      // empty pps group on the final byte: walk completes with the summary
      '{8'h00, 1'b1, 1'b1, 1'b0, 3'd1, 32'd4},
      // record cut inside the header
      '{8'h01, 1'b0, 1'b0, 1'b0, 3'd0, 32'd0},
      '{8'h02, 1'b1, 1'b1, 1'b1, 3'd1, 32'd0}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_in_byte;
   logic        req_in_last;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic        rsp_byte_valid;
   logic        rsp_record_done;
   logic        rsp_status;
   logic [2:0]  rsp_length_field_bytes;
   logic [31:0] rsp_total_length;
   logic        rsp_run_end;
   logic        csr_write_enable;
   logic        csr_index;
   logic        csr_write_data;

   // predictor state: the record walk as the block should see it
   ncab_pkg::cfg_type   csr_mirror;
   ncab_pkg::phase_type walk_phase;
   logic [4:0]  hdr_count;
   logic [7:0]  groups_todo;
   logic [15:0] units_todo;
   logic [15:0] payload_todo;
   logic [7:0]  held_byte;
   logic [2:0]  prefix_bytes;
   logic [31:0] annexb_len;
   logic        walk_done;

   annexb_out_type annexb_step[$];      // responses caused by the current request
   annexb_out_type annexb_expected[$];  // responses still owed by the block
   logic [7:0]  record_bytes[$];        // random record under construction

   bit req_gaps = 1'b1;
   bit rsp_gaps = 1'b1;
   int stall_left = 0;
   int mismatch_count = 0;
   int req_count = 0;
   int rsp_count = 0;
   int summary_count = 0;
   int truncated_count = 0;

   always #2 clock = ~clock;

   nal_config_to_annexb_unit i_dut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_in_byte            (req_in_byte),
      .req_in_last            (req_in_last),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_out_byte           (rsp_out_byte),
      .rsp_byte_valid         (rsp_byte_valid),
      .rsp_record_done        (rsp_record_done),
      .rsp_status             (rsp_status),
      .rsp_length_field_bytes (rsp_length_field_bytes),
      .rsp_total_length       (rsp_total_length),
      .rsp_run_end            (rsp_run_end),
      .csr_write_enable       (csr_write_enable),
      .csr_index              (csr_index),
      .csr_write_data         (csr_write_data)
   );

   // ------------------------------------------------------------------------
   // predictor
   // ------------------------------------------------------------------------

   // end of record: walk back to its reset state, registers untouched
   function automatic void clear_walk();
      walk_phase   = ncab_pkg::PH_HEADER;
      hdr_count    = '0;
      groups_todo  = '0;
      units_todo   = '0;
      payload_todo = '0;
      held_byte    = '0;
      prefix_bytes = 3'd1;
      annexb_len   = '0;
      walk_done    = 1'b0;
   endfunction

   // after a count or a unit: next unit, next group, or walk complete
   function automatic void pick_next_step();
      if (units_todo != 0) begin
         walk_phase = ncab_pkg::PH_SIZE_HI;
      end else if (groups_todo != 0) begin
         walk_phase = csr_mirror.hevc_mode ? ncab_pkg::PH_HEVC_TYPE : ncab_pkg::PH_AVC_COUNT;
      end else begin
         walk_phase = ncab_pkg::PH_DONE;
         walk_done  = 1'b1;
      end
   endfunction

   function automatic void emit(logic [7:0] d, logic v, logic done, logic st);
      annexb_step.push_back('{data: d, byte_valid: v, record_done: done, status: st,
                              prefix: prefix_bytes, total: annexb_len, run_end: 1'b0});
   endfunction

   // one record byte in, the annex-b responses it causes into annexb_step
   function automatic void convert_byte(logic [7:0] b, logic last);
      logic [32:0] sum;
      annexb_step.delete();
      case (walk_phase)
         ncab_pkg::PH_HEADER: begin
            hdr_count = hdr_count + 5'd1;
            if (hdr_count >= (csr_mirror.hevc_mode ? ncab_pkg::HEVC_HEADER_BYTES
                                                   : ncab_pkg::AVC_HEADER_BYTES)) begin
               prefix_bytes = {1'b0, b[1:0]} + 3'd1;
               if (csr_mirror.hevc_mode) begin
                  walk_phase = ncab_pkg::PH_HEVC_ARRAYS;
               end else begin
                  groups_todo = ncab_pkg::AVC_GROUPS;
                  walk_phase  = ncab_pkg::PH_AVC_COUNT;
               end
            end
         end
         ncab_pkg::PH_AVC_COUNT: begin
            groups_todo = groups_todo - 8'd1;
            units_todo  = {11'd0, b[4:0] & ncab_pkg::AVC_COUNT_MASK};
            pick_next_step();
         end
         ncab_pkg::PH_HEVC_ARRAYS: begin
            groups_todo = b;
            units_todo  = '0;
            pick_next_step();
         end
         ncab_pkg::PH_HEVC_TYPE: begin
            groups_todo = groups_todo - 8'd1;
            walk_phase  = ncab_pkg::PH_COUNT_HI;
         end
         ncab_pkg::PH_COUNT_HI: begin
            held_byte  = b;
            walk_phase = ncab_pkg::PH_COUNT_LO;
         end
         ncab_pkg::PH_COUNT_LO: begin
            units_todo = {held_byte, b};
            pick_next_step();
         end
         ncab_pkg::PH_SIZE_HI: begin
            held_byte  = b;
            walk_phase = ncab_pkg::PH_SIZE_LO;
         end
         ncab_pkg::PH_SIZE_LO: begin
            payload_todo = {held_byte, b};
            units_todo   = units_todo - 16'd1;
            // running length saturates at the top of its width
            sum = {1'b0, annexb_len} + {17'd0, payload_todo} + 33'(START_CODE_LEN);
            annexb_len = sum[32] ? '1 : sum[31:0];
            if (!csr_mirror.length_only) begin
               for (int i = 0; i < START_CODE_LEN; i++) begin
                  emit((i == START_CODE_LEN - 1) ? 8'h01 : 8'h00, 1'b1, 1'b0, 1'b0);
               end
            end
            if (payload_todo != 0) begin
               walk_phase = ncab_pkg::PH_PAYLOAD;
            end else begin
               pick_next_step();
            end
         end
         ncab_pkg::PH_PAYLOAD: begin
            if (!csr_mirror.length_only) begin
               emit(b, 1'b1, 1'b0, 1'b0);
            end
            payload_todo = payload_todo - 16'd1;
            if (payload_todo == 0) begin
               pick_next_step();
            end
         end
         default: begin
            // trailing bytes after a complete walk are dropped
         end
      endcase
      if (last) begin
         emit(8'h00, 1'b0, 1'b1, !walk_done);
         clear_walk();
      end
      if (annexb_step.size() > 0) begin
         annexb_step[annexb_step.size() - 1].run_end = 1'b1;
      end
   endfunction

   // ------------------------------------------------------------------------
   // checking
   // ------------------------------------------------------------------------

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      $display("mismatch: %s", msg);
   endtask

   function automatic string show(annexb_out_type r);
      return $sformatf("byte %h valid %b done %b status %b prefix %0d total %0d end %b",
                       r.data, r.byte_valid, r.record_done, r.status, r.prefix,
                       r.total, r.run_end);
   endfunction

   task automatic check_response();
      annexb_out_type seen;
      annexb_out_type want;
      seen = '{data: rsp_out_byte, byte_valid: rsp_byte_valid,
               record_done: rsp_record_done, status: rsp_status,
               prefix: rsp_length_field_bytes, total: rsp_total_length,
               run_end: rsp_run_end};
      rsp_count++;
      if (seen.record_done === 1'b1) begin
         summary_count++;
         if (seen.status === 1'b1) truncated_count++;
      end
      if (annexb_expected.size() == 0) begin
         report_mismatch($sformatf("response %0d with nothing owed: %s", rsp_count, show(seen)));
      end else begin
         want = annexb_expected.pop_front();
         if (seen !== want) begin
            report_mismatch($sformatf("response %0d got %s / want %s",
                                      rsp_count, show(seen), show(want)));
         end
      end
   endtask

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      return ($urandom_range(0, 9) == 0) ? int'($urandom_range(8, 30))
                                         : int'($urandom_range(1, 3));
   endfunction

   // response side: sample at the edge, then decide the stall for the next cycle
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) check_response();
         if (stall_left > 0) begin
            rsp_stall  <= 1'b1;
            stall_left <= stall_left - 1;
         end else begin
            rsp_stall <= 1'b0;
            if (rsp_gaps && $urandom_range(0, 4) == 0) stall_left <= pick_gap();
         end
      end
   end

   // ------------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------------

   // one request: optional gap, hold until accepted, then predict
   task automatic send_req(input stim_row_type row);
      if (req_gaps && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat (pick_gap()) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_in_byte <= row.data;
      req_in_last <= row.last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      req_count++;
      convert_byte(row.data, row.last);
      // typed rows pin the record summary to hand-derived values
      if (row.typed) begin
         annexb_step[annexb_step.size() - 1].status = row.status;
         annexb_step[annexb_step.size() - 1].prefix = row.prefix;
         annexb_step[annexb_step.size() - 1].total  = row.total;
      end
      foreach (annexb_step[i]) annexb_expected.push_back(annexb_step[i]);
   endtask

   // sender stops until every owed response is out, then lets the block settle
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (annexb_expected.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // both registers, back to back, enable held high across the pair
   task automatic write_settings(input logic hevc, input logic lonly);
      csr_write_enable <= 1'b1;
      csr_index        <= ncab_pkg::CSR_HEVC_MODE;
      csr_write_data   <= hevc;
      @(posedge clock);
      csr_index        <= ncab_pkg::CSR_LENGTH_ONLY;
      csr_write_data   <= lonly;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      csr_mirror.hevc_mode   = hevc;
      csr_mirror.length_only = lonly;
   endtask

   // small units of up to five payload bytes
   task automatic push_unit();
      int usize;
      usize = int'($urandom_range(0, 5));
      record_bytes.push_back(8'(usize >> 8));
      record_bytes.push_back(8'(usize));
      repeat (usize) record_bytes.push_back(8'($urandom));
   endtask

   // well-formed record with random header, counts and payload
   task automatic build_record(input bit hevc_layout);
      int arrays;
      int units;
      record_bytes.delete();
      repeat (int'(hevc_layout ? ncab_pkg::HEVC_HEADER_BYTES
                               : ncab_pkg::AVC_HEADER_BYTES)) begin
         record_bytes.push_back(8'($urandom));
      end
      if (hevc_layout) begin
         arrays = $urandom_range(0, 3);
         record_bytes.push_back(8'(arrays));
         repeat (arrays) begin
            units = $urandom_range(0, 2);
            record_bytes.push_back(8'($urandom));  // nal type byte, not checked
            record_bytes.push_back(8'h00);
            record_bytes.push_back(8'(units));
            repeat (units) push_unit();
         end
      end else begin
         // sps then pps group, random reserved bits above the count
         repeat (2) begin
            units = $urandom_range(0, 2);
            record_bytes.push_back({3'($urandom), 5'(units)});
            repeat (units) push_unit();
         end
      end
   endtask

   // one settings phase of random records
   task automatic run_random_phase(input bit hevc, input bit lonly, input bit gaps,
                                   input bit pause_midway, input bit leave_open);
      int  sent;
      int  cut;
      int  style;
      bit  paused;
      wait_idle();
      write_settings(hevc, lonly);
      req_gaps = gaps;
      rsp_gaps = gaps;
      sent     = 0;
      paused   = 1'b0;
      while (sent < PHASE_REQUESTS) begin
         style = $urandom_range(0, 19);
         // now and then a record in the other layout
         build_record(($urandom_range(0, 9) == 0) ? !hevc : hevc);
         if (style < 3) begin
            // noise: a few random bytes as a record
            record_bytes.delete();
            repeat ($urandom_range(1, 6)) record_bytes.push_back(8'($urandom));
         end else if (style < 6) begin
            // truncated somewhere before its end
            cut = $urandom_range(1, record_bytes.size() - 1);
            while (record_bytes.size() > cut) void'(record_bytes.pop_back());
         end else begin
            // complete, maybe with trailing bytes
            repeat ($urandom_range(0, 2)) record_bytes.push_back(8'($urandom));
         end
         foreach (record_bytes[i]) begin
            send_req('{record_bytes[i], 1'(i == record_bytes.size() - 1),
                       1'b0, 1'b0, 3'd0, 32'd0});
         end
         sent += record_bytes.size();
         if (pause_midway && !paused && sent >= PHASE_REQUESTS / 2) begin
            wait_idle();
            paused = 1'b1;
         end
      end
      // half a record left open, finished under the next settings
      if (leave_open) begin
         build_record(hevc);
         for (int i = 0; i < record_bytes.size() / 2; i++) begin
            send_req('{record_bytes[i], 1'b0, 1'b0, 1'b0, 3'd0, 32'd0});
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------------
   initial begin
      req_valid        <= 1'b0;
      req_in_byte      <= 8'h00;
      req_in_last      <= 1'b0;
      csr_write_enable <= 1'b0;
      csr_index        <= ncab_pkg::CSR_HEVC_MODE;
      csr_write_data   <= 1'b0;
      csr_mirror = '0;
      clear_walk();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed table: avcC, byte output
      write_settings(1'b0, 1'b0);
      for (int i = 0; i < DIRECTED_ROWS; i++) send_req(DIRECTED[i]);

      // random phases through both layouts and both output modes
      run_random_phase(1'b0, 1'b0, 1'b1, 1'b1, 1'b1);
      run_random_phase(1'b1, 1'b0, 1'b1, 1'b1, 1'b0);
      run_random_phase(1'b1, 1'b1, 1'b1, 1'b0, 1'b1);
      run_random_phase(1'b0, 1'b1, 1'b0, 1'b0, 1'b0);  // no idling on either side

      wait_idle();
      if (annexb_expected.size() != 0) begin
         report_mismatch($sformatf("%0d responses never came", annexb_expected.size()));
      end

      $display("covered %0d requests and %0d responses, %0d record summaries (%0d truncated)",
               req_count, rsp_count, summary_count, truncated_count);
      $display("avcC and hvcC layouts, byte and length-only output, records across settings");
      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // run limit, far above the slowest legal run
   initial begin
      #(4_000_000);
      $display("status: fail");
      $finish;
   end

endmodule
